[rtl/sfd_pkg.sv]
// Shared types, constants and helpers for the sensor frame decoder.
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int FRAME_BYTES = 388;
  localparam int MAX_FLOWS   = 8;
  localparam int MAX_TEMPS   = 8;

  localparam int HDR_LEN  = 32;
  localparam int FLOW_LEN = 28;
  localparam int TEMP_LEN = 16;
  localparam int CRC_LEN  = 4;
  localparam int HLD_LEN  = HDR_LEN + CRC_LEN;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC    = 32'h3153575A;

  localparam int CNT_W   = $clog2(FRAME_BYTES + 2);
  localparam int MEM_AW  = $clog2(FRAME_BYTES);
  localparam int REC_END = HDR_LEN + MAX_FLOWS * FLOW_LEN + MAX_TEMPS * TEMP_LEN;
  localparam int ADDR_LIM = (REC_END > FRAME_BYTES) ? REC_END : FRAME_BYTES;
  localparam int ADDR_W  = $clog2(ADDR_LIM + 1);
  localparam int LD_W    = $clog2(HLD_LEN + 1);
  localparam int BUF_N   = HLD_LEN;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_FLOW      = 3'd1;
  localparam logic [2:0] KIND_TEMP      = 3'd2;
  localparam logic [2:0] KIND_BAD_LEN   = 3'd3;
  localparam logic [2:0] KIND_BAD_MAGIC = 3'd4;
  localparam logic [2:0] KIND_BAD_VER   = 3'd5;
  localparam logic [2:0] KIND_BAD_CRC   = 3'd6;
  localparam logic [2:0] KIND_BAD_COUNT = 3'd7;

  typedef enum logic [1:0] {
    LD_HDR  = 2'd0,
    LD_FLOW = 2'd1,
    LD_TEMP = 2'd2
  } ld_kind_e;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_HDR_LD   = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_FLOW_LD  = 7'b0001000,
    S_FLOW_OUT = 7'b0010000,
    S_TEMP_LD  = 7'b0100000,
    S_TEMP_OUT = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [4:0]  record_index;
    logic [63:0] wide_a;
    logic [63:0] wide_b;
    logic [31:0] mid_a;
    logic [31:0] mid_b;
    logic [31:0] mid_c;
    logic [15:0] half_a;
    logic [15:0] half_b;
    logic [7:0]  small_a;
    logic [7:0]  small_b;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic       ld_go;
    ld_kind_e   ld_kind;
    logic [4:0] ld_rec;
    logic       emit;
    logic [2:0] out_kind;
    logic [4:0] out_rec;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic       ld_done;
    logic [2:0] chk_kind;
    logic [7:0] nflows;
    logic [7:0] ntemps;
  } sts_t;

  // Reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/sfd_ctrl.sv]
// Sequencer that walks checks, header and records after each frame.
`timescale 1ns / 1ps
module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic frame_done_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e     state_q, state_d;
  logic [4:0] rec_q, rec_d;
  logic [7:0] nf_q, nf_d, nt_q, nt_d;
  logic [7:0] rec_nxt;

  assign rec_nxt = {3'd0, rec_q} + 8'd1;
  assign busy_o  = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    rec_d   = rec_q;
    nf_d    = nf_q;
    nt_d    = nt_q;
    cmd_o   = '0;
    cmd_o.ld_kind = LD_HDR;
    case (state_q)
      S_IDLE: begin
        if (frame_done_i) begin
          cmd_o.ld_go = 1'b1;
          state_d = S_HDR_LD;
        end
      end
      S_HDR_LD: begin
        if (sts_i.ld_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.emit     = 1'b1;
        cmd_o.out_kind = sts_i.chk_kind;
        nf_d  = sts_i.nflows;
        nt_d  = sts_i.ntemps;
        rec_d = '0;
        if (sts_i.chk_kind != KIND_HEADER) begin
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.nflows != 8'd0) begin
          cmd_o.ld_go   = 1'b1;
          cmd_o.ld_kind = LD_FLOW;
          state_d = S_FLOW_LD;
        end else if (sts_i.ntemps != 8'd0) begin
          cmd_o.ld_go   = 1'b1;
          cmd_o.ld_kind = LD_TEMP;
          state_d = S_TEMP_LD;
        end else begin
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FLOW_LD: begin
        if (sts_i.ld_done) state_d = S_FLOW_OUT;
      end
      S_FLOW_OUT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.out_kind = KIND_FLOW;
        cmd_o.out_rec  = rec_q;
        if (rec_nxt != nf_q) begin
          rec_d = rec_q + 5'd1;
          cmd_o.ld_go   = 1'b1;
          cmd_o.ld_kind = LD_FLOW;
          state_d = S_FLOW_LD;
        end else if (nt_q != 8'd0) begin
          rec_d = '0;
          cmd_o.ld_go   = 1'b1;
          cmd_o.ld_kind = LD_TEMP;
          state_d = S_TEMP_LD;
        end else begin
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TEMP_LD: begin
        if (sts_i.ld_done) state_d = S_TEMP_OUT;
      end
      S_TEMP_OUT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.out_kind = KIND_TEMP;
        cmd_o.out_rec  = rec_q;
        if (rec_nxt != nt_q) begin
          rec_d = rec_q + 5'd1;
          cmd_o.ld_go   = 1'b1;
          cmd_o.ld_kind = LD_TEMP;
          state_d = S_TEMP_LD;
        end else begin
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.ld_rec = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rec_q   <= '0;
      nf_q    <= '0;
      nt_q    <= '0;
    end else begin
      state_q <= state_d;
      rec_q   <= rec_d;
      nf_q    <= nf_d;
      nt_q    <= nt_d;
    end
  end

endmodule

[rtl/sfd_dp.sv]
// Datapath: byte count, CRC, frame memory, record loader and result register.
`timescale 1ns / 1ps
module sfd_dp
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_take_i,
  input  in_t        in_i,
  input  logic       cfg_take_i,
  input  logic [7:0] cfg_data_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       result_valid_o,
  output out_t       result_o
);

  logic [7:0]        mem [FRAME_BYTES];
  logic [CNT_W-1:0]  cnt_q, cnt_inc;
  logic [31:0]       crc_q, crc_upd, crc_fin_q;
  logic              len_ok_q;
  logic [7:0]        major_q;

  logic              ld_act_q;
  logic [LD_W-1:0]   ld_idx_q, ld_len_q, widx_q;
  ld_kind_e          ld_kind_q;
  logic [ADDR_W-1:0] ld_base_q, base_d, raddr;
  logic              rv_q, oob_q;
  logic [7:0]        rdata_q;
  logic [BUF_N*8-1:0] rbuf_q;

  logic              res_v_q;
  out_t              res_q, res_d;

  // Input side: store, count and CRC.
  assign cnt_inc = (cnt_q < CNT_W'(FRAME_BYTES + 1)) ? cnt_q + CNT_W'(1) : cnt_q;
  assign crc_upd = (cnt_q < CNT_W'(FRAME_BYTES - CRC_LEN)) ?
                   crc_byte(crc_q, in_i.frame_byte) : crc_q;

  always_ff @(posedge clk_i) begin
    if (in_take_i && cnt_q < CNT_W'(FRAME_BYTES)) begin
      mem[cnt_q[MEM_AW-1:0]] <= in_i.frame_byte;
    end
    rdata_q <= mem[raddr[MEM_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      crc_q    <= CRC_INIT;
      major_q  <= 8'd1;
    end else begin
      if (cfg_take_i) major_q <= cfg_data_i;
      if (in_take_i) begin
        if (in_i.frame_end) begin
          cnt_q <= '0;
          crc_q <= CRC_INIT;
        end else begin
          cnt_q <= cnt_inc;
          crc_q <= crc_upd;
        end
      end
    end
  end

  // Latch the frame summary at the end mark.
  always_ff @(posedge clk_i) begin
    if (in_take_i && in_i.frame_end) begin
      len_ok_q  <= (cnt_inc == CNT_W'(FRAME_BYTES));
      crc_fin_q <= ~crc_upd;
    end
  end

  // Loader: fetch one byte a cycle into the record buffer.
  always_comb begin
    case (cmd_i.ld_kind)
      LD_FLOW: base_d = ADDR_W'(HDR_LEN) + ADDR_W'(cmd_i.ld_rec) * ADDR_W'(FLOW_LEN);
      LD_TEMP: base_d = ADDR_W'(HDR_LEN + MAX_FLOWS * FLOW_LEN)
                        + ADDR_W'(cmd_i.ld_rec) * ADDR_W'(TEMP_LEN);
      default: base_d = '0;
    endcase
    if (ld_kind_q == LD_HDR && ld_idx_q >= LD_W'(HDR_LEN)) begin
      raddr = ADDR_W'(FRAME_BYTES - HLD_LEN) + ADDR_W'(ld_idx_q);
    end else begin
      raddr = ld_base_q + ADDR_W'(ld_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_act_q <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      rv_q <= ld_act_q;
      if (cmd_i.ld_go) begin
        ld_act_q <= 1'b1;
      end else if (ld_act_q && ld_idx_q == ld_len_q - LD_W'(1)) begin
        ld_act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_go) begin
      ld_idx_q  <= '0;
      ld_kind_q <= cmd_i.ld_kind;
      ld_base_q <= base_d;
      case (cmd_i.ld_kind)
        LD_FLOW: ld_len_q <= LD_W'(FLOW_LEN);
        LD_TEMP: ld_len_q <= LD_W'(TEMP_LEN);
        default: ld_len_q <= LD_W'(HLD_LEN);
      endcase
    end else if (ld_act_q) begin
      ld_idx_q <= ld_idx_q + LD_W'(1);
    end
    widx_q <= ld_idx_q;
    oob_q  <= (raddr >= ADDR_W'(FRAME_BYTES));
    if (rv_q) begin
      rbuf_q[widx_q*8 +: 8] <= oob_q ? 8'd0 : rdata_q;
    end
  end

  // Frame checks over the loaded header and CRC trailer.
  always_comb begin
    sts_o.ld_done = rv_q && (widx_q == ld_len_q - LD_W'(1));
    sts_o.nflows  = rbuf_q[30*8 +: 8];
    sts_o.ntemps  = rbuf_q[31*8 +: 8];
    if (!len_ok_q || rbuf_q[6*8 +: 16] != 16'(FRAME_BYTES)) begin
      sts_o.chk_kind = KIND_BAD_LEN;
    end else if (rbuf_q[0 +: 32] != MAGIC) begin
      sts_o.chk_kind = KIND_BAD_MAGIC;
    end else if (rbuf_q[4*8 +: 8] != major_q) begin
      sts_o.chk_kind = KIND_BAD_VER;
    end else if (rbuf_q[HDR_LEN*8 +: 32] != crc_fin_q) begin
      sts_o.chk_kind = KIND_BAD_CRC;
    end else if (rbuf_q[30*8 +: 8] > 8'(MAX_FLOWS) || rbuf_q[31*8 +: 8] > 8'(MAX_TEMPS)) begin
      sts_o.chk_kind = KIND_BAD_COUNT;
    end else begin
      sts_o.chk_kind = KIND_HEADER;
    end
  end

  // Result formatting from fixed buffer offsets.
  always_comb begin
    res_d = '0;
    res_d.result_kind  = cmd_i.out_kind;
    res_d.last_result  = cmd_i.out_last;
    case (cmd_i.out_kind)
      KIND_HEADER: begin
        res_d.wide_a  = rbuf_q[20*8 +: 64];
        res_d.mid_a   = rbuf_q[8*8 +: 32];
        res_d.mid_b   = rbuf_q[12*8 +: 32];
        res_d.mid_c   = rbuf_q[16*8 +: 32];
        res_d.half_a  = rbuf_q[28*8 +: 16];
        res_d.half_b  = {8'd0, rbuf_q[31*8 +: 8]};
        res_d.small_a = rbuf_q[5*8 +: 8];
        res_d.small_b = rbuf_q[30*8 +: 8];
      end
      KIND_FLOW: begin
        res_d.record_index = cmd_i.out_rec;
        res_d.small_a = rbuf_q[0 +: 8];
        res_d.half_a  = rbuf_q[2*8 +: 16];
        res_d.wide_a  = rbuf_q[4*8 +: 64];
        res_d.wide_b  = rbuf_q[12*8 +: 64];
        res_d.mid_a   = rbuf_q[20*8 +: 32];
        res_d.mid_b   = rbuf_q[24*8 +: 32];
      end
      KIND_TEMP: begin
        res_d.record_index = cmd_i.out_rec;
        res_d.wide_a  = rbuf_q[0 +: 64];
        res_d.mid_a   = rbuf_q[8*8 +: 32];
        res_d.half_b  = rbuf_q[12*8 +: 16];
        res_d.half_a  = rbuf_q[14*8 +: 16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

[rtl/sensor_frame_decoder_unit.sv]
// Top level of the sensor frame decoder.
`timescale 1ns / 1ps
// Bytes are taken one per cycle while busy is low; a byte without the end
// mark produces nothing and never raises busy. On the end byte the block goes
// busy, reads the 32-byte header and 4-byte CRC trailer from its frame memory
// one byte a cycle, then emits one error result, or a header result followed
// by each flow record and each temperature record. The single read port of
// the frame memory sets this byte rate. Each result is valid for exactly one
// cycle on result_valid_o and cannot be stalled; last_result marks the frame's
// final one. The configuration channel is always ready and must only be written
// while busy is low.
module sensor_frame_decoder_unit
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        in_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output out_t       result_o
);

  cmd_t cmd;
  sts_t sts;
  logic take;

  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  sfd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_done_i (take && in_i.frame_end),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  sfd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_take_i      (take),
    .in_i           (in_i),
    .cfg_take_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
